// File: hw/rtl/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types and constants for the character display nibble sequencer:
// request codes, microcode control word layout and the init command list.
// ----------------------------------------------------------------------------
package cls_pkg;

   // Request codes carried in the func field.
   localparam logic [2:0] FUNC_CMD    = 3'd0;
   localparam logic [2:0] FUNC_DATA   = 3'd1;
   localparam logic [2:0] FUNC_CURSOR = 3'd2;
   localparam logic [2:0] FUNC_LIGHT  = 3'd3;
   localparam logic [2:0] FUNC_INIT   = 3'd4;

   // Microprogram layout.
   localparam int unsigned PC_W = 5;
   localparam logic [PC_W-1:0] PC_BYTE  = 5'd0;
   localparam logic [PC_W-1:0] PC_LIGHT = 5'd6;
   localparam logic [PC_W-1:0] PC_INIT  = 5'd7;
   localparam logic [PC_W-1:0] PC_LAST  = 5'd19;

   // Index of the final entry in the init command list.
   localparam logic [2:0] LAST_CMD_IDX = 3'd5;

   // Wait times in microseconds.
   localparam logic [15:0] WAIT_EN_HIGH  = 16'd10;
   localparam logic [15:0] WAIT_EN_LOW   = 16'd100;
   localparam logic [15:0] WAIT_BYTE     = 16'd200;
   localparam logic [15:0] WAIT_SLOW     = 16'd5100;
   localparam logic [15:0] WAIT_INIT_MID = 16'd300;
   localparam logic [15:0] WAIT_POWER    = 16'd50000;

   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME  = 8'h02;

   typedef enum logic [1:0] {
      NIB_HI,
      NIB_LO,
      NIB_CONST,
      NIB_ZERO
   } nib_sel_type;

   typedef enum logic [2:0] {
      W_0,
      W_10,
      W_100,
      W_BYTE_END,
      W_5100,
      W_300,
      W_50000
   } wait_sel_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_END,
      SEQ_BYTE_END,
      SEQ_START_CMDS
   } seq_op_type;

   typedef struct packed {
      nib_sel_type  nib_sel;
      logic [3:0]   nib_const;
      logic         en;
      wait_sel_type wait_sel;
      seq_op_type   seq_op;
   } ctrl_word_type;

   // Sequencer to datapath strobes.
   typedef struct packed {
      logic load;
      logic step;
      logic last;
      logic next_cmd;
      logic start_cmds;
   } dp_ctrl_type;

   // Datapath to sequencer status.
   typedef struct packed {
      logic out_free;
      logic more_cmds;
   } dp_status_type;

   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h28;
         3'd1:    c = 8'h28;
         3'd2:    c = 8'h08;
         3'd3:    c = 8'h01;
         3'd4:    c = 8'h06;
         default: c = 8'h0C;
      endcase
      return c;
   endfunction

endpackage

// File: hw/rtl/cls_if.sv
// ----------------------------------------------------------------------------
// cls_req_if / cls_rsp_if
// Valid/ready channels for display requests and expander port writes.
// ----------------------------------------------------------------------------
interface cls_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] value;
   logic [7:0] col;
   logic [7:0] row;
   logic       light_on;

   modport source (output valid, func, value, col, row, light_on, input ready);
   modport sink   (input valid, func, value, col, row, light_on, output ready);
endinterface

interface cls_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  port_byte;
   logic [15:0] wait_us;
   logic        last;

   modport source (output valid, port_byte, wait_us, last, input ready);
   modport sink   (input valid, port_byte, wait_us, last, output ready);
endinterface

// File: hw/rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Microcoded sequencer that turns display requests into expander port writes.
// ----------------------------------------------------------------------------
// After a request's transfer the sequencer registers its start step; the first
// port write then enters the output register once that is free. Writes leave at
// one per cycle while the sink is ready: 6 for a command, character or cursor
// request, 1 for backlight, 49 for init. A new request is taken the cycle after
// the final write enters the output register. Reset (synchronous) turns the
// backlight off and idles the sequencer.
module char_lcd_nibble_sequencer (
   input  logic      clock,
   input  logic      reset,
   cls_req_if.sink   req_ch,
   cls_rsp_if.source rsp_ch
);
   import cls_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   logic            accept;
   logic            step_go;
   ctrl_word_type   uword;
   dp_ctrl_type     dp_ctrl;
   dp_status_type   dp_status;

   cls_urom u_urom (
      .pc    (pc_ff),
      .uword (uword)
   );

   cls_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .dp_ctrl      (dp_ctrl),
      .uword        (uword),
      .req_func     (req_ch.func),
      .req_value    (req_ch.value),
      .req_col      (req_ch.col),
      .req_row      (req_ch.row),
      .req_light_on (req_ch.light_on),
      .dp_status    (dp_status),
      .rsp_ch       (rsp_ch)
   );

   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign step_go      = busy_ff && dp_status.out_free;

   always_comb begin
      pc_in              = pc_ff;
      busy_in            = busy_ff;
      dp_ctrl            = '0;
      dp_ctrl.step       = step_go;

      // Unused request codes are taken and dropped without any write.
      if (accept && req_ch.func <= FUNC_INIT) begin
         dp_ctrl.load = 1'b1;
         busy_in      = 1'b1;
         priority if (req_ch.func == FUNC_LIGHT) begin
            pc_in = PC_LIGHT;
         end else if (req_ch.func == FUNC_INIT) begin
            pc_in = PC_INIT;
         end else begin
            pc_in = PC_BYTE;
         end
      end else if (step_go) begin
         unique case (uword.seq_op)
            SEQ_NEXT: begin
               pc_in = pc_ff + PC_W'(1);
            end
            SEQ_END: begin
               busy_in      = 1'b0;
               dp_ctrl.last = 1'b1;
            end
            SEQ_BYTE_END: begin
               if (dp_status.more_cmds) begin
                  dp_ctrl.next_cmd = 1'b1;
                  pc_in            = PC_BYTE;
               end else begin
                  busy_in      = 1'b0;
                  dp_ctrl.last = 1'b1;
               end
            end
            default: begin
               dp_ctrl.start_cmds = 1'b1;
               pc_in              = PC_BYTE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_BYTE;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   // The step counter never leaves the microprogram while a request runs.
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= PC_LAST)
      else $error("step counter outside the microprogram");

   // A new request is only taken once every earlier write but the final one has left.
   a_accept_after_last: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(rsp_ch.valid && !rsp_ch.last))
      else $error("request taken while an earlier request still has writes pending");

   // A closing step frees the sequencer and presents a write marked last.
   a_end_marks_last: assert property (@(posedge clock) disable iff (reset)
      (step_go && uword.seq_op == SEQ_END) |=> (!busy_ff && rsp_ch.valid && rsp_ch.last))
      else $error("closing step did not finish the request");

endmodule

// File: hw/rtl/cls_urom.sv
// ----------------------------------------------------------------------------
// cls_urom
// Microprogram store: one control word per step of the write sequences.
// ----------------------------------------------------------------------------
module cls_urom (
   input  logic [cls_pkg::PC_W-1:0] pc,
   output cls_pkg::ctrl_word_type   uword
);
   import cls_pkg::*;

   // Steps 0-5 send one byte as two nibbles, step 6 is the lone backlight
   // write, steps 7-19 are the power-on part of the init sequence, which then
   // loops through the byte routine for each init command.
   always_comb begin
      unique case (pc)
         5'd0:    uword = '{NIB_HI,    4'h0, 1'b0, W_0,        SEQ_NEXT};
         5'd1:    uword = '{NIB_HI,    4'h0, 1'b1, W_10,       SEQ_NEXT};
         5'd2:    uword = '{NIB_HI,    4'h0, 1'b0, W_100,      SEQ_NEXT};
         5'd3:    uword = '{NIB_LO,    4'h0, 1'b0, W_0,        SEQ_NEXT};
         5'd4:    uword = '{NIB_LO,    4'h0, 1'b1, W_10,       SEQ_NEXT};
         5'd5:    uword = '{NIB_LO,    4'h0, 1'b0, W_BYTE_END, SEQ_BYTE_END};
         5'd6:    uword = '{NIB_ZERO,  4'h0, 1'b0, W_0,        SEQ_END};
         5'd7:    uword = '{NIB_ZERO,  4'h0, 1'b0, W_50000,    SEQ_NEXT};
         5'd8:    uword = '{NIB_CONST, 4'h3, 1'b0, W_0,        SEQ_NEXT};
         5'd9:    uword = '{NIB_CONST, 4'h3, 1'b1, W_10,       SEQ_NEXT};
         5'd10:   uword = '{NIB_CONST, 4'h3, 1'b0, W_5100,     SEQ_NEXT};
         5'd11:   uword = '{NIB_CONST, 4'h3, 1'b0, W_0,        SEQ_NEXT};
         5'd12:   uword = '{NIB_CONST, 4'h3, 1'b1, W_10,       SEQ_NEXT};
         5'd13:   uword = '{NIB_CONST, 4'h3, 1'b0, W_5100,     SEQ_NEXT};
         5'd14:   uword = '{NIB_CONST, 4'h3, 1'b0, W_0,        SEQ_NEXT};
         5'd15:   uword = '{NIB_CONST, 4'h3, 1'b1, W_10,       SEQ_NEXT};
         5'd16:   uword = '{NIB_CONST, 4'h3, 1'b0, W_300,      SEQ_NEXT};
         5'd17:   uword = '{NIB_CONST, 4'h2, 1'b0, W_0,        SEQ_NEXT};
         5'd18:   uword = '{NIB_CONST, 4'h2, 1'b1, W_10,       SEQ_NEXT};
         5'd19:   uword = '{NIB_CONST, 4'h2, 1'b0, W_300,      SEQ_START_CMDS};
         default: uword = '{NIB_ZERO,  4'h0, 1'b0, W_0,        SEQ_END};
      endcase
   end

endmodule

// File: hw/rtl/cls_dpath.sv
// ----------------------------------------------------------------------------
// cls_dpath
// Datapath: byte and mode registers, init command index, backlight state,
// port byte and wait formation, and the output register.
// ----------------------------------------------------------------------------
module cls_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  cls_pkg::dp_ctrl_type   dp_ctrl,
   input  cls_pkg::ctrl_word_type uword,
   input  logic [2:0]             req_func,
   input  logic [7:0]             req_value,
   input  logic [7:0]             req_col,
   input  logic [7:0]             req_row,
   input  logic                   req_light_on,
   output cls_pkg::dp_status_type dp_status,
   cls_rsp_if.source              rsp_ch
);
   import cls_pkg::*;

   logic [7:0]  byte_ff, byte_in;
   logic        rs_ff, rs_in;
   logic        init_ff, init_in;
   logic [2:0]  idx_ff, idx_in;
   logic        bl_ff, bl_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  port_ff, port_in;
   logic [15:0] wait_ff, wait_in;
   logic        last_ff, last_in;

   logic [3:0]  col_sat;
   logic        row_sat;
   logic [7:0]  cursor_byte;
   logic [3:0]  nib;
   logic        rs_bit;
   logic [15:0] wait_val;
   logic [15:0] byte_end_wait;

   assign col_sat     = (req_col > 8'd15) ? 4'hF : req_col[3:0];
   assign row_sat     = (req_row != 8'd0);
   assign cursor_byte = {1'b1, row_sat, 2'b00, col_sat};

   // Clear and home need the long settle; data writes never match since RS is set.
   assign byte_end_wait = (!rs_ff && (byte_ff == CMD_CLEAR || byte_ff == CMD_HOME)) ?
                          WAIT_SLOW : WAIT_BYTE;

   always_comb begin
      unique case (uword.nib_sel)
         NIB_HI: begin
            nib    = byte_ff[7:4];
            rs_bit = rs_ff;
         end
         NIB_LO: begin
            nib    = byte_ff[3:0];
            rs_bit = rs_ff;
         end
         NIB_CONST: begin
            nib    = uword.nib_const;
            rs_bit = 1'b0;
         end
         default: begin
            nib    = 4'h0;
            rs_bit = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (uword.wait_sel)
         W_0:        wait_val = 16'd0;
         W_10:       wait_val = WAIT_EN_HIGH;
         W_100:      wait_val = WAIT_EN_LOW;
         W_BYTE_END: wait_val = byte_end_wait;
         W_5100:     wait_val = WAIT_SLOW;
         W_300:      wait_val = WAIT_INIT_MID;
         W_50000:    wait_val = WAIT_POWER;
         default:    wait_val = 16'd0;
      endcase
   end

   always_comb begin
      byte_in      = byte_ff;
      rs_in        = rs_ff;
      init_in      = init_ff;
      idx_in       = idx_ff;
      bl_in        = bl_ff;
      out_valid_in = out_valid_ff;
      port_in      = port_ff;
      wait_in      = wait_ff;
      last_in      = last_ff;

      if (dp_ctrl.load) begin
         byte_in = (req_func == FUNC_CURSOR) ? cursor_byte : req_value;
         rs_in   = (req_func == FUNC_DATA);
         init_in = (req_func == FUNC_INIT);
         if (req_func == FUNC_LIGHT) begin
            bl_in = req_light_on;
         end else if (req_func == FUNC_INIT) begin
            bl_in = 1'b1;
         end
      end

      if (dp_ctrl.step) begin
         out_valid_in = 1'b1;
         port_in      = {nib, bl_ff, uword.en, 1'b0, rs_bit};
         wait_in      = wait_val;
         last_in      = dp_ctrl.last;
         if (dp_ctrl.start_cmds) begin
            idx_in  = 3'd0;
            byte_in = init_cmd(3'd0);
         end else if (dp_ctrl.next_cmd) begin
            idx_in  = idx_ff + 3'd1;
            byte_in = init_cmd(idx_ff + 3'd1);
         end
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         bl_ff        <= 1'b0;
         init_ff      <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         bl_ff        <= bl_in;
         init_ff      <= init_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rs_ff   <= rs_in;
      port_ff <= port_in;
      wait_ff <= wait_in;
      last_ff <= last_in;
   end

   assign dp_status.out_free  = !out_valid_ff || rsp_ch.ready;
   assign dp_status.more_cmds = init_ff && (idx_ff != LAST_CMD_IDX);

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.port_byte = port_ff;
   assign rsp_ch.wait_us   = wait_ff;
   assign rsp_ch.last      = last_ff;

endmodule

// File: tb/char_lcd_nibble_sequencer_test.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_test
// Self-checking bench for the display nibble sequencer. Requests go in from a
// bursty driver, and port writes come out to a receiver that stalls in
// changing patterns. A predictor turns each accepted request into the port
// writes it must cause, and the monitor checks them in order.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_test;
   import cls_pkg::*;

   localparam logic [7:0]  PORT_RS       = 8'h01;
   localparam logic [7:0]  PORT_EN       = 8'h04;
   localparam logic [7:0]  PORT_BL       = 8'h08;
   localparam logic [7:0]  PORT_IDLE     = 8'h00;
   localparam logic [7:0]  CMD_SET_ADDR  = 8'h80;
   localparam logic [7:0]  ROW1_OFFSET   = 8'h40;
   localparam logic [7:0]  WAKE_NIBBLE   = 8'h30;
   localparam logic [7:0]  MODE4_NIBBLE  = 8'h20;
   localparam logic [15:0] WAIT_SETUP    = 16'd0;
   localparam logic [7:0]  INIT_CMDS [6] = '{8'h28, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
   localparam int          RANDOM_ITEMS  = 165;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          TAIL_CYCLES   = 20;
   localparam int          MAX_REPORTS   = 10;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] value;
      logic [7:0] col;
      logic [7:0] row;
      logic       light_on;
   } lcd_request_type;

   typedef struct packed {
      logic [7:0]  port_byte;
      logic [15:0] wait_us;
      logic        last;
   } port_write_type;

   typedef struct {
      lcd_request_type req;
      bit              drain_first;
   } pending_request_type;

   logic clock;
   logic reset;

   cls_req_if req_if ();
   cls_rsp_if rsp_if ();

   char_lcd_nibble_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   pending_request_type pending_requests[$];
   port_write_type      expected_writes[$];
   lcd_request_type     active_request;
   logic                lcd_backlight;

   int total_requests;
   int requests_accepted;
   int writes_checked;
   int mismatches;
   int cycle_count;
   int burst_left;
   int gap_left;
   int stall_mode;
   int stall_span;
   int func_seen [8];

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ----- Predictor --------------------------------------------------------

   function automatic void add_write(input logic [7:0] port, input logic [15:0] wait_us);
      port_write_type w;
      w.port_byte = port | (lcd_backlight ? PORT_BL : 8'h00);
      w.wait_us   = wait_us;
      w.last      = 1'b0;
      expected_writes.push_back(w);
   endfunction

   function automatic void add_nibble(input logic [7:0] bits, input logic [15:0] final_wait);
      add_write(bits, WAIT_SETUP);
      add_write(bits | PORT_EN, WAIT_EN_HIGH);
      add_write(bits & ~PORT_EN, final_wait);
   endfunction

   function automatic void add_byte(input logic [7:0] v, input logic [7:0] mode,
                                    input logic [15:0] end_wait);
      add_nibble((v & 8'hF0) | mode, WAIT_EN_LOW);
      add_nibble({v[3:0], 4'h0} | mode, end_wait);
   endfunction

   function automatic void add_command(input logic [7:0] c);
      add_byte(c, 8'h00, (c == CMD_CLEAR || c == CMD_HOME) ? WAIT_SLOW : WAIT_BYTE);
   endfunction

   function automatic void predict_port_writes(input lcd_request_type r);
      int         before_count;
      logic [7:0] cur_col;
      logic [7:0] cur_row;
      before_count = expected_writes.size();
      case (r.func)
         FUNC_CMD: begin
            add_command(r.value);
         end
         FUNC_DATA: begin
            add_byte(r.value, PORT_RS, WAIT_BYTE);
         end
         FUNC_CURSOR: begin
            cur_col = (r.col > 8'd15) ? 8'd15 : r.col;
            cur_row = (r.row > 8'd1) ? 8'd1 : r.row;
            add_command(CMD_SET_ADDR | (cur_col + ((cur_row != 0) ? ROW1_OFFSET : 8'h00)));
         end
         FUNC_LIGHT: begin
            lcd_backlight = r.light_on;
            add_write(PORT_IDLE, WAIT_SETUP);
         end
         FUNC_INIT: begin
            lcd_backlight = 1'b1;
            add_write(PORT_IDLE, WAIT_POWER);
            add_nibble(WAKE_NIBBLE, WAIT_SLOW);
            add_nibble(WAKE_NIBBLE, WAIT_SLOW);
            add_nibble(WAKE_NIBBLE, WAIT_INIT_MID);
            add_nibble(MODE4_NIBBLE, WAIT_INIT_MID);
            foreach (INIT_CMDS[i]) add_command(INIT_CMDS[i]);
         end
         default: begin
            // Unused codes are swallowed without any port write.
         end
      endcase
      if (expected_writes.size() > before_count)
         expected_writes[expected_writes.size() - 1].last = 1'b1;
   endfunction

   // ----- Stimulus ---------------------------------------------------------

   function automatic void queue_request(input logic [2:0] func, input logic [7:0] value,
                                         input logic [7:0] col, input logic [7:0] row,
                                         input logic light_on, input bit drain_first);
      pending_request_type p;
      p.req.func        = func;
      p.req.value       = value;
      p.req.col         = col;
      p.req.row         = row;
      p.req.light_on    = light_on;
      p.drain_first     = drain_first;
      pending_requests.push_back(p);
   endfunction

   initial begin : stimulus
      int         counted;
      int         sel;
      logic [2:0] f;
      logic [7:0] v;
      logic [7:0] c;
      logic [7:0] r;

      req_if.valid    = 1'b0;
      req_if.func     = FUNC_CMD;
      req_if.value    = 8'h00;
      req_if.col      = 8'h00;
      req_if.row      = 8'h00;
      req_if.light_on = 1'b0;
      rsp_if.ready    = 1'b0;
      reset           = 1'b1;

      // Directed part: backlight still off after reset, field extremes, clear and
      // home, cursor saturation, backlight both ways, init and the unused codes.
      queue_request(FUNC_CMD,    8'h00, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_CMD,    8'hFF, 8'hFF, 8'hFF, 1'b1, 0);
      queue_request(FUNC_CMD,    CMD_CLEAR, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_CMD,    CMD_HOME, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_DATA,   8'h00, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_DATA,   8'hFF, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_LIGHT,  8'h00, 8'h00, 8'h00, 1'b1, 0);
      queue_request(FUNC_DATA,   8'hA5, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_CURSOR, 8'h00, 8'd0,  8'd0,  1'b0, 0);
      queue_request(FUNC_CURSOR, 8'h00, 8'd15, 8'd1,  1'b0, 0);
      queue_request(FUNC_CURSOR, 8'h00, 8'd16, 8'd2,  1'b0, 0);
      queue_request(FUNC_CURSOR, 8'hFF, 8'd255, 8'd255, 1'b1, 0);
      queue_request(FUNC_CURSOR, 8'h00, 8'd7,  8'd0,  1'b0, 0);
      queue_request(FUNC_LIGHT,  8'hFF, 8'hFF, 8'hFF, 1'b0, 1);
      queue_request(FUNC_DATA,   8'h5A, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_INIT,   8'h00, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_DATA,   8'h41, 8'h00, 8'h00, 1'b1, 0);
      queue_request(3'd5,        8'hFF, 8'hFF, 8'hFF, 1'b1, 0);
      queue_request(3'd6,        8'h00, 8'h00, 8'h00, 1'b0, 0);
      queue_request(3'd7,        8'h12, 8'h34, 8'h56, 1'b1, 0);
      queue_request(FUNC_CURSOR, 8'h00, 8'd200, 8'd1, 1'b0, 1);
      queue_request(FUNC_LIGHT,  8'h00, 8'h00, 8'h00, 1'b0, 0);
      queue_request(FUNC_CMD,    CMD_CLEAR, 8'h00, 8'h00, 1'b0, 0);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 25)      f = FUNC_CMD;
         else if (sel < 55) f = FUNC_DATA;
         else if (sel < 75) f = FUNC_CURSOR;
         else if (sel < 88) f = FUNC_LIGHT;
         else if (sel < 92) f = FUNC_INIT;
         else               f = 3'($urandom_range(5, 7));
         v = 8'($urandom_range(0, 255));
         if (f == FUNC_CMD && $urandom_range(0, 7) == 0)
            v = ($urandom_range(0, 1) != 0) ? CMD_CLEAR : CMD_HOME;
         // Mostly near the saturation edges, sometimes anywhere in range.
         c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 17));
         r = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 2));
         queue_request(f, v, c, r, 1'($urandom_range(0, 1)), $urandom_range(0, 29) == 0);
         if (f <= FUNC_INIT) counted++;
      end
      total_requests = pending_requests.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (requests_accepted < total_requests || expected_writes.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_writes.size() > 0) begin
         $display("%0d expected port writes never arrived", expected_writes.size());
         mismatches++;
      end
      $display("Covered %0d requests: %0d command, %0d character, %0d cursor, %0d backlight,",
               requests_accepted, func_seen[FUNC_CMD], func_seen[FUNC_DATA],
               func_seen[FUNC_CURSOR], func_seen[FUNC_LIGHT]);
      $display("%0d init and %0d unused-code requests; %0d port writes checked.",
               func_seen[FUNC_INIT], func_seen[5] + func_seen[6] + func_seen[7],
               writes_checked);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d failures", mismatches);
         $display("status: fail");
      end
      $finish;
   end

   // ----- Request driver ---------------------------------------------------

   initial begin
      lcd_backlight     = 1'b0;
      requests_accepted = 0;
      writes_checked    = 0;
      mismatches        = 0;
      cycle_count       = 0;
      burst_left        = 4;
      gap_left          = 0;
      stall_mode        = 0;
      stall_span        = 0;
      foreach (func_seen[i]) func_seen[i] = 0;
   end

   always @(posedge clock) begin : request_driver
      logic hold;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_port_writes(active_request);
            func_seen[active_request.func]++;
            requests_accepted++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 8);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         hold = req_if.valid && !req_if.ready;
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         (!pending_requests[0].drain_first || expected_writes.size() == 0)) begin
               // A drain-first request waits until the block has sent everything.
               active_request = pending_requests[0].req;
               void'(pending_requests.pop_front());
               req_if.valid    <= 1'b1;
               req_if.func     <= active_request.func;
               req_if.value    <= active_request.value;
               req_if.col      <= active_request.col;
               req_if.row      <= active_request.row;
               req_if.light_on <= active_request.light_on;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ----- Write monitor ----------------------------------------------------

   always @(posedge clock) begin : write_monitor
      port_write_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_writes.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected port write %h wait %0d last %b",
                           rsp_if.port_byte, rsp_if.wait_us, rsp_if.last);
            end else begin
               want = expected_writes.pop_front();
               writes_checked++;
               if (rsp_if.port_byte !== want.port_byte || rsp_if.wait_us !== want.wait_us ||
                   rsp_if.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("write %0d: expected port %h wait %0d last %b, got %h %0d %b",
                              writes_checked, want.port_byte, want.wait_us, want.last,
                              rsp_if.port_byte, rsp_if.wait_us, rsp_if.last);
               end
            end
         end

         // The receiver switches between stall patterns after spans of random length.
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(8, 80);
         end else begin
            stall_span--;
         end
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= (cycle_count % 4 == 0);
            default: rsp_if.ready <= (cycle_count % 8 < 5);
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

endmodule
